FILE: hw/rtl/card_number_luhn_classify_macros.svh
// Assertion helpers for the card number checker.
// They sample on clk and stay quiet while arst_n is low.
`ifndef CARD_NUMBER_LUHN_CLASSIFY_MACROS_SVH
`define CARD_NUMBER_LUHN_CLASSIFY_MACROS_SVH

// Same-cycle implication.
`define LUHN_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("luhn check: same-cycle implication failed");

// Next-cycle implication.
`define LUHN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("luhn check: next-cycle implication failed");

`endif

FILE: hw/rtl/luhn_pkg.sv
package luhn_pkg;

	// Width of the binary card number and the decimal digits it can hold.
	localparam int NUMBER_BITS = 63;
	localparam int DIGITS      = (NUMBER_BITS * 30103) / 100000 + 1;
	localparam int BCD_BITS    = DIGITS * 4;
	localparam int COUNT_BITS  = $clog2(DIGITS + 1);
	localparam int CNT_BITS    = $clog2(NUMBER_BITS + 1);

	// Brand class codes.
	localparam logic [1:0] CLASS_INVALID = 2'd0;
	localparam logic [1:0] CLASS_FIFTEEN = 2'd1;
	localparam logic [1:0] CLASS_SIXTEEN = 2'd2;
	localparam logic [1:0] CLASS_FOUR    = 2'd3;

	// Lengths that select a brand.
	localparam logic [COUNT_BITS-1:0] LEN_THIRTEEN = COUNT_BITS'(13);
	localparam logic [COUNT_BITS-1:0] LEN_FIFTEEN  = COUNT_BITS'(15);
	localparam logic [COUNT_BITS-1:0] LEN_SIXTEEN  = COUNT_BITS'(16);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic bit_step;
		logic digit_step;
	} b2d_ctl_t;

	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

	typedef struct packed {
		logic [1:0]            brand_class;
		logic                  luhn_ok;
		logic [COUNT_BITS-1:0] digit_count;
	} scan_res_t;

endpackage

FILE: hw/rtl/luhn_if.sv
interface luhn_card_if;
	logic                             valid;
	logic                             ready;
	logic [luhn_pkg::NUMBER_BITS-1:0] card_number;

	modport source(output valid, output card_number, input ready);
	modport sink(input valid, input card_number, output ready);
endinterface

interface luhn_result_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      brand_class;
	logic                            luhn_ok;
	logic [luhn_pkg::COUNT_BITS-1:0] digit_count;

	modport source(output valid, output brand_class, output luhn_ok, output digit_count,
		input ready);
	modport sink(input valid, input brand_class, input luhn_ok, input digit_count,
		output ready);
endinterface

FILE: hw/rtl/luhn_b2d.sv
// Shift-and-add-3 binary to BCD converter, one binary bit per step, then
// shifts the BCD word right one digit per step to feed the digit scan.
module luhn_b2d (
	input  logic                             clk,
	input  luhn_pkg::b2d_ctl_t               ctl,
	input  logic [luhn_pkg::NUMBER_BITS-1:0] number,
	output logic [3:0]                       digit
);

	logic [luhn_pkg::NUMBER_BITS-1:0] bin_q;
	logic [luhn_pkg::BCD_BITS-1:0]    bcd_q;
	logic [luhn_pkg::BCD_BITS-1:0]    bcd_adj;

	// Each digit of five or more gets three added before the left shift.
	always_comb begin
		for (int i = 0; i < luhn_pkg::DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q <= number;
			bcd_q <= '0;
		end else if (ctl.bit_step) begin
			bin_q <= {bin_q[luhn_pkg::NUMBER_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[luhn_pkg::BCD_BITS-2:0], bin_q[luhn_pkg::NUMBER_BITS-1]};
		end else if (ctl.digit_step) begin
			bcd_q <= {4'd0, bcd_q[luhn_pkg::BCD_BITS-1:4]};
		end
	end

	assign digit = bcd_q[3:0];

endmodule

FILE: hw/rtl/luhn_dscan.sv
// Walks the decimal digits from the least significant end, one per step.
// Keeps the Luhn sum modulo ten, the digit count and the two leading digits.
module luhn_dscan (
	input  logic                clk,
	input  logic                arst_n,
	input  luhn_pkg::scan_ctl_t ctl,
	input  logic [3:0]          digit,
	output luhn_pkg::scan_res_t res
);

	logic [luhn_pkg::COUNT_BITS-1:0] index_q;
	logic [luhn_pkg::COUNT_BITS-1:0] count_q;
	logic [3:0]                      sum_q;
	logic [3:0]                      prev_q;
	logic [3:0]                      lead_hi_q;
	logic [3:0]                      lead_lo_q;

	logic [4:0] twice;
	logic [4:0] contrib;
	logic [4:0] sum_raw;
	logic [4:0] sum_wrap;

	always_comb begin
		twice = {digit, 1'b0};
		if (!index_q[0]) begin
			contrib = {1'b0, digit};
		end else if (twice >= 5'd10) begin
			contrib = twice - 5'd9;
		end else begin
			contrib = twice;
		end
		sum_raw = {1'b0, sum_q} + contrib;
		sum_wrap = (sum_raw >= 5'd10) ? sum_raw - 5'd10 : sum_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (ctl.clear) begin
			index_q <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (ctl.step) begin
			index_q <= index_q + 1'b1;
			sum_q   <= sum_wrap[3:0];
			if (digit != 4'd0) begin
				count_q <= index_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			prev_q    <= '0;
			lead_hi_q <= '0;
			lead_lo_q <= '0;
		end else if (ctl.step) begin
			prev_q <= digit;
			if (digit != 4'd0) begin
				lead_hi_q <= digit;
				lead_lo_q <= prev_q;
			end
		end
	end

	always_comb begin
		res.digit_count = count_q;
		res.luhn_ok     = (sum_q == 4'd0);
		res.brand_class = luhn_pkg::CLASS_INVALID;
		if (res.luhn_ok) begin
			priority if (count_q == luhn_pkg::LEN_SIXTEEN) begin
				if (lead_hi_q == 4'd5 && lead_lo_q >= 4'd1 && lead_lo_q <= 4'd5) begin
					res.brand_class = luhn_pkg::CLASS_SIXTEEN;
				end else if (lead_hi_q == 4'd4) begin
					res.brand_class = luhn_pkg::CLASS_FOUR;
				end
			end else if (count_q == luhn_pkg::LEN_FIFTEEN) begin
				if (lead_hi_q == 4'd3 && (lead_lo_q == 4'd4 || lead_lo_q == 4'd7)) begin
					res.brand_class = luhn_pkg::CLASS_FIFTEEN;
				end
			end else if (count_q == luhn_pkg::LEN_THIRTEEN) begin
				if (lead_hi_q == 4'd4) begin
					res.brand_class = luhn_pkg::CLASS_FOUR;
				end
			end else begin
				res.brand_class = luhn_pkg::CLASS_INVALID;
			end
		end
	end

endmodule

FILE: hw/rtl/card_number_luhn_classify.sv
// The result beat becomes valid once the card has gone through the conversion steps,
// the digit steps and the finish step.
// A new card is taken only after the previous one has left the finish phase, a pace set
// by the bit-serial BCD converter followed by the one-digit-per-cycle scan; a waiting
// result holds back only the finish cycle of the next card.
// Reset: arst_n clears the controller, the scan counters and the result valid flag.
`include "card_number_luhn_classify_macros.svh"

module card_number_luhn_classify (
	input  logic          clk,
	input  logic          arst_n,
	luhn_card_if.sink     card,
	luhn_result_if.source result
);

	// The controller walks through four phases. In the idle phase a card beat is
	// taken and loaded into the converter. The convert phase shifts the binary
	// number into a BCD register one bit per cycle with the usual add-3 fixup.
	// The scan phase then shifts that BCD word out one digit per cycle into the
	// scan unit, which forms the Luhn sum, the length and the leading digits.
	// The finish phase moves the classification into the output register as soon
	// as that register is free, so a new card can be taken while the result waits.

	luhn_pkg::state_t state_q;
	luhn_pkg::state_t state_next;

	logic [luhn_pkg::CNT_BITS-1:0] cnt_q;
	logic                          accept;
	logic                          out_load;
	logic                          out_free;
	logic                          convert_last;
	logic                          res_fail;

	luhn_pkg::b2d_ctl_t  b2d_ctl;
	luhn_pkg::scan_ctl_t scan_ctl;
	luhn_pkg::scan_res_t scan_res;
	logic [3:0]          digit;

	logic                            res_valid_q;
	logic [1:0]                      brand_class_q;
	logic                            luhn_ok_q;
	logic [luhn_pkg::COUNT_BITS-1:0] digit_count_q;

	assign accept   = card.valid && card.ready;
	assign out_free = !res_valid_q || result.ready;

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			luhn_pkg::ST_IDLE: begin
				if (accept) begin
					state_next = luhn_pkg::ST_CONVERT;
				end
			end
			luhn_pkg::ST_CONVERT: begin
				if (cnt_q == luhn_pkg::CNT_BITS'(1)) begin
					state_next = luhn_pkg::ST_SCAN;
				end
			end
			luhn_pkg::ST_SCAN: begin
				if (cnt_q == luhn_pkg::CNT_BITS'(1)) begin
					state_next = luhn_pkg::ST_FINISH;
				end
			end
			luhn_pkg::ST_FINISH: begin
				if (out_free) begin
					state_next = luhn_pkg::ST_IDLE;
				end
			end
			default: state_next = luhn_pkg::ST_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		card.ready          = (state_q == luhn_pkg::ST_IDLE);
		b2d_ctl.load        = accept;
		b2d_ctl.bit_step    = (state_q == luhn_pkg::ST_CONVERT);
		b2d_ctl.digit_step  = (state_q == luhn_pkg::ST_SCAN);
		scan_ctl.clear      = accept;
		scan_ctl.step       = (state_q == luhn_pkg::ST_SCAN);
		out_load            = (state_q == luhn_pkg::ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= luhn_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				cnt_q <= luhn_pkg::CNT_BITS'(luhn_pkg::NUMBER_BITS);
			end else if (state_q == luhn_pkg::ST_CONVERT &&
				cnt_q == luhn_pkg::CNT_BITS'(1)) begin
				cnt_q <= luhn_pkg::CNT_BITS'(luhn_pkg::DIGITS);
			end else if (state_q == luhn_pkg::ST_CONVERT || state_q == luhn_pkg::ST_SCAN) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	luhn_b2d u_b2d (
		.clk    (clk),
		.ctl    (b2d_ctl),
		.number (card.card_number),
		.digit  (digit)
	);

	luhn_dscan u_dscan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.digit  (digit),
		.res    (scan_res)
	);

	// Output register: holds one finished result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			brand_class_q <= scan_res.brand_class;
			luhn_ok_q     <= scan_res.luhn_ok;
			digit_count_q <= scan_res.digit_count;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.brand_class = brand_class_q;
	assign result.luhn_ok     = luhn_ok_q;
	assign result.digit_count = digit_count_q;

	assign convert_last = (state_q == luhn_pkg::ST_CONVERT) && (cnt_q == luhn_pkg::CNT_BITS'(1));
	assign res_fail     = result.valid && !result.luhn_ok;

	// A taken card always starts the conversion in the next cycle.
	`LUHN_ASSERT_NEXT(a_accept_starts_convert, accept, state_q == luhn_pkg::ST_CONVERT)
	// The last conversion step hands over to the digit scan.
	`LUHN_ASSERT_NEXT(a_convert_to_scan, convert_last, state_q == luhn_pkg::ST_SCAN)
	// A number that fails the Luhn check never carries a brand.
	`LUHN_ASSERT_IMPLY(a_fail_is_invalid, res_fail, result.brand_class == luhn_pkg::CLASS_INVALID)

endmodule
